// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_CLK checks a property at the rising clock edge and ignores it while
// the reset is high; ASSERT_ALWAYS checks it at every edge, reset or not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/nirp_pkg.sv
`timescale 1ns / 1ps

package nirp_pkg;

  localparam int WIDTH_W = 16;
  localparam int FRAME_W = 32;

  typedef enum logic [2:0] {
    ST_NONE             = 3'd0,
    ST_BAD_LEADER_MARK  = 3'd1,
    ST_BAD_LEADER_SPACE = 3'd2,
    ST_BAD_BIT_MARK     = 3'd3,
    ST_BAD_BIT_SPACE    = 3'd4,
    ST_TIMEOUT          = 3'd5,
    ST_DONE             = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    REG_START_PULSE_MIN = 3'd0,
    REG_START_PULSE_MAX = 3'd1,
    REG_START_SPACE_MIN = 3'd2,
    REG_START_SPACE_MAX = 3'd3,
    REG_SHORT_MIN       = 3'd4,
    REG_SHORT_MAX       = 3'd5,
    REG_ONE_SPACE_MIN   = 3'd6,
    REG_ONE_SPACE_MAX   = 3'd7
  } cfg_idx_t;

  localparam logic [WIDTH_W-1:0] RST_START_PULSE_MIN = 16'd7500;
  localparam logic [WIDTH_W-1:0] RST_START_PULSE_MAX = 16'd10500;
  localparam logic [WIDTH_W-1:0] RST_START_SPACE_MIN = 16'd3500;
  localparam logic [WIDTH_W-1:0] RST_START_SPACE_MAX = 16'd5500;
  localparam logic [WIDTH_W-1:0] RST_SHORT_MIN       = 16'd350;
  localparam logic [WIDTH_W-1:0] RST_SHORT_MAX       = 16'd800;
  localparam logic [WIDTH_W-1:0] RST_ONE_SPACE_MIN   = 16'd1400;
  localparam logic [WIDTH_W-1:0] RST_ONE_SPACE_MAX   = 16'd1900;

  // Timing windows, all bounds exclusive
  typedef struct packed {
    logic [WIDTH_W-1:0] start_pulse_min;
    logic [WIDTH_W-1:0] start_pulse_max;
    logic [WIDTH_W-1:0] start_space_min;
    logic [WIDTH_W-1:0] start_space_max;
    logic [WIDTH_W-1:0] short_min;
    logic [WIDTH_W-1:0] short_max;
    logic [WIDTH_W-1:0] one_space_min;
    logic [WIDTH_W-1:0] one_space_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         command;
    logic [7:0]         address;
    logic [FRAME_W-1:0] raw_frame;
    logic               frame_valid;
    status_t            status;
  } result_t;

endpackage

// File: rtl/nirp_cfg_regs.sv
`timescale 1ns / 1ps

module nirp_cfg_regs
  import nirp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  cfg_idx_t           wr_index,
  input  logic [WIDTH_W-1:0] wr_data,
  output cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pulse_min <= RST_START_PULSE_MIN;
      cfg.start_pulse_max <= RST_START_PULSE_MAX;
      cfg.start_space_min <= RST_START_SPACE_MIN;
      cfg.start_space_max <= RST_START_SPACE_MAX;
      cfg.short_min       <= RST_SHORT_MIN;
      cfg.short_max       <= RST_SHORT_MAX;
      cfg.one_space_min   <= RST_ONE_SPACE_MIN;
      cfg.one_space_max   <= RST_ONE_SPACE_MAX;
    end else if (wr_en) begin
      case (wr_index)
        REG_START_PULSE_MIN: cfg.start_pulse_min <= wr_data;
        REG_START_PULSE_MAX: cfg.start_pulse_max <= wr_data;
        REG_START_SPACE_MIN: cfg.start_space_min <= wr_data;
        REG_START_SPACE_MAX: cfg.start_space_max <= wr_data;
        REG_SHORT_MIN:       cfg.short_min       <= wr_data;
        REG_SHORT_MAX:       cfg.short_max       <= wr_data;
        REG_ONE_SPACE_MIN:   cfg.one_space_min   <= wr_data;
        REG_ONE_SPACE_MAX:   cfg.one_space_max   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/nirp_decode.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nirp_decode
  import nirp_pkg::*;
#(
  parameter int FRAME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic               cmd,
  input  logic [WIDTH_W-1:0] width_us,
  input  cfg_t               cfg,
  output result_t            res
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_START_PULSE = 3'd1,
    PH_START_SPACE = 3'd2,
    PH_BIT_PULSE   = 3'd3,
    PH_BIT_SPACE   = 3'd4
  } phase_t;

  phase_t             phase, phase_next;
  logic [FRAME_W-1:0] shift_data, shift_data_next;
  logic [CNT_W-1:0]   bits_cnt, bits_cnt_next;
  logic               hit_lead_mark, hit_lead_space, hit_short, hit_one;

  function automatic logic in_window(input logic [WIDTH_W-1:0] w,
                                     input logic [WIDTH_W-1:0] lo,
                                     input logic [WIDTH_W-1:0] hi);
    in_window = (w > lo) && (w < hi);
  endfunction

  assign hit_lead_mark  = in_window(width_us, cfg.start_pulse_min, cfg.start_pulse_max);
  assign hit_lead_space = in_window(width_us, cfg.start_space_min, cfg.start_space_max);
  assign hit_short      = in_window(width_us, cfg.short_min, cfg.short_max);
  assign hit_one        = in_window(width_us, cfg.one_space_min, cfg.one_space_max);

  always_comb begin
    phase_next      = phase;
    shift_data_next = shift_data;
    bits_cnt_next   = bits_cnt;
    res             = '0;
    res.status      = ST_NONE;
    if (cmd) begin
      // timeout tick: abandon any frame in progress
      if (phase != PH_IDLE) begin
        phase_next = PH_IDLE;
        res.status = ST_TIMEOUT;
      end
    end else begin
      case (phase)
        PH_IDLE: phase_next = PH_START_PULSE;
        PH_START_PULSE: begin
          if (hit_lead_mark) begin
            phase_next = PH_START_SPACE;
          end else begin
            phase_next = PH_IDLE;
            res.status = ST_BAD_LEADER_MARK;
          end
        end
        PH_START_SPACE: begin
          if (hit_lead_space) begin
            phase_next      = PH_BIT_PULSE;
            shift_data_next = '0;
            bits_cnt_next   = '0;
          end else begin
            phase_next = PH_IDLE;
            res.status = ST_BAD_LEADER_SPACE;
          end
        end
        PH_BIT_PULSE: begin
          if (hit_short) begin
            phase_next = PH_BIT_SPACE;
          end else begin
            phase_next = PH_IDLE;
            res.status = ST_BAD_BIT_MARK;
          end
        end
        PH_BIT_SPACE: begin
          // one window wins where the windows overlap
          shift_data_next = {shift_data[FRAME_W-2:0], hit_one};
          if (hit_one || hit_short) begin
            bits_cnt_next = bits_cnt + 1'b1;
            if (bits_cnt_next == FRAME_CNT) begin
              phase_next      = PH_IDLE;
              res.status      = ST_DONE;
              res.frame_valid = 1'b1;
              res.raw_frame   = shift_data_next;
            end else begin
              phase_next = PH_BIT_PULSE;
            end
          end else begin
            phase_next = PH_IDLE;
            res.status = ST_BAD_BIT_SPACE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    res.address = res.raw_frame[31:24];
    res.command = res.raw_frame[15:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      shift_data <= '0;
      bits_cnt   <= '0;
    end else if (go) begin
      phase      <= phase_next;
      shift_data <= shift_data_next;
      bits_cnt   <= bits_cnt_next;
    end
  end

  `ASSERT_CLK(a_done_to_idle, clk, rst, go && res.status == ST_DONE |=> phase == PH_IDLE, "frame done did not return to idle")
  `ASSERT_CLK(a_tick_to_idle, clk, rst, go && cmd |=> phase == PH_IDLE, "timeout tick left machine busy")
  `ASSERT_CLK(a_frame_count, clk, rst, go && res.frame_valid |-> res.status == ST_DONE && bits_cnt_next == FRAME_CNT, "frame reported with wrong bit count")

endmodule

// File: rtl/nec_ir_pulse_decoder_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// NEC infrared frame decoder working on measured edge intervals.
// Input stream (s_axis_*): one beat per event. tuser[0] is cmd (0 edge event,
// 1 timeout tick); tdata[15:0] is the width in microseconds since the last edge.
// Output stream (m_axis_*): exactly one beat per input beat, in order.
// tuser carries status and frame_valid; tdata carries raw_frame, address and
// command, all zero unless a complete frame was received.
// Configuration (cfg_*): eight 16-bit window bounds, indexed 0..7, always
// ready; write them only while the decoder is idle.
// Path: an accepted beat is held in the input register, and the decode
// logic and state update run between that register and the result register,
// which presents the result on m_axis_*.
// Throughput: one beat per cycle while m_axis_tready is high; the phase
// machine is the only loop, closing through the window compares and bit shift.
// Stalls: while m_axis_tready is low the result holds, the input register
// keeps one more beat, and s_axis_tready drops only when both are full.
// Reset (rst, synchronous): windows return to their default timings, the
// phase machine goes idle and both registers empty.
module nec_ir_pulse_decoder_core
  import nirp_pkg::*;
#(
  parameter int FRAME_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // [15:0] width_us
  input  logic [0:0]   s_axis_tuser,  // [0] cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // [31:0] raw_frame, [39:32] address, [47:40] command
  output logic [3:0]   m_axis_tuser,  // [2:0] status, [3] frame_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  cfg_t               cfg;
  result_t            res, out_res;
  logic               in_valid, out_valid, adv;
  logic               in_cmd;
  logic [WIDTH_W-1:0] in_width;

  assign cfg_ready = 1'b1;

  nirp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_idx_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance the held beat whenever the result register is free or draining
  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd   <= s_axis_tuser[0];
      in_width <= s_axis_tdata;
    end
  end

  nirp_decode #(
    .FRAME_BITS (FRAME_BITS)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .go       (adv),
    .cmd      (in_cmd),
    .width_us (in_width),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.command, out_res.address, out_res.raw_frame};
  assign m_axis_tuser  = {out_res.frame_valid, out_res.status};

  `ASSERT_CLK(a_adv_fills_out, clk, rst, adv |=> out_valid, "decoded beat did not reach output register")
  `ASSERT_CLK(a_ready_low_full, clk, rst, !s_axis_tready |-> in_valid && out_valid, "input stalled with free room")
  `ASSERT_CLK(a_held_beat_stable, clk, rst, in_valid && !adv |=> in_valid && $stable(in_width) && $stable(in_cmd), "held input beat changed")

endmodule
